// ----- hw/rtl/rmsf_pkg.sv -----
// Shared constants, types and state encodings of the regression maximum-slope finder.
package rmsf_pkg;

  localparam int MAX_SETS = 64;
  localparam int DATA_W   = 24;
  localparam int CNT_W    = $clog2(MAX_SETS + 1);
  localparam int SX_W     = DATA_W + CNT_W;
  localparam int SXX_W    = 2 * DATA_W - 1 + CNT_W;
  localparam int LO_W     = SXX_W / 2;
  localparam int MUL_W    = SX_W;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int MAG_W    = 2 * SX_W;
  localparam int ACC_W    = MAG_W + 1;
  localparam int SLOPE_W  = 31;
  localparam int FRAC_W   = 16;
  localparam int SAT_SH   = SLOPE_W - FRAC_W;
  localparam int STEP_W   = $clog2(SLOPE_W);

  // Where a multiplier product is written back, in the cycle after it is issued.
  typedef enum logic [3:0] {
    DST_NONE,
    DST_XX,
    DST_XY,
    DST_NUM_SUB,
    DST_NUM_ADD,
    DST_NUM_ADD_HI,
    DST_DEN_SUB,
    DST_DEN_ADD,
    DST_DEN_ADD_HI
  } dst_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MXY,
    ST_SXSY,
    ST_SXSX,
    ST_NXXL,
    ST_NXXH,
    ST_NXYL,
    ST_NXYH,
    ST_SETTLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN
  } div_state_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    dst_t                    dst;
  } mul_req_t;

  typedef struct packed {
    dst_t                     dst;
    logic signed [PROD_W-1:0] prod;
  } mul_res_t;

  typedef struct packed {
    logic               done;
    logic               skip;
    logic [SLOPE_W-1:0] quot;
  } div_res_t;

endpackage

// ----- hw/rtl/rmsf_mul.sv -----
// Shared signed multiplier with a registered product and write-back tag.
module rmsf_mul import rmsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_res_t res
);

  dst_t                     dst_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_q <= DST_NONE;
    end else begin
      dst_q <= req.dst;
    end
    prod_q <= $signed(req.a) * $signed(req.b);
  end

  assign res.dst  = dst_q;
  assign res.prod = prod_q;

endmodule

// ----- hw/rtl/rmsf_div.sv -----
// Iterative restoring divider giving a saturated unsigned Q15.16 slope magnitude.
module rmsf_div import rmsf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output div_res_t                res
);

  div_state_t         dstate;
  div_state_t         dstate_next;
  logic [MAG_W-1:0]   num_mag;
  logic [MAG_W-1:0]   den_mag;
  logic [MAG_W-1:0]   rem;
  logic [SLOPE_W-1:0] low_bits;
  logic [SLOPE_W-1:0] quot;
  logic [STEP_W-1:0]  step;
  logic               done_q;
  logic               skip_q;
  logic               den_zero;
  logic               sat;
  logic [MAG_W:0]     trial;
  logic [MAG_W:0]     diff;
  logic               fits;
  logic               last_step;

  assign den_zero  = (den_mag == '0);
  // The quotient reaches 2^31 exactly when num >= den * 2^15.
  assign sat       = ((MAG_W + SAT_SH)'(num_mag)) >= {den_mag, {SAT_SH{1'b0}}};
  assign trial     = {rem, low_bits[SLOPE_W-1]};
  assign diff      = trial - {1'b0, den_mag};
  assign fits      = (trial >= {1'b0, den_mag});
  assign last_step = (step == STEP_W'(SLOPE_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= DV_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  always_comb begin
    dstate_next = dstate;
    case (dstate)
      DV_IDLE: begin
        if (start) begin
          dstate_next = DV_CHECK;
        end
      end
      DV_CHECK: begin
        if (den_zero || sat) begin
          dstate_next = DV_IDLE;
        end else begin
          dstate_next = DV_RUN;
        end
      end
      DV_RUN: begin
        if (last_step) begin
          dstate_next = DV_IDLE;
        end
      end
      default: dstate_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (dstate)
        DV_IDLE: begin
          if (start) begin
            num_mag <= num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
            den_mag <= den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
          end
        end
        DV_CHECK: begin
          if (den_zero) begin
            done_q <= 1'b1;
            skip_q <= 1'b1;
          end else if (sat) begin
            done_q <= 1'b1;
            skip_q <= 1'b0;
            quot   <= '1;
          end else begin
            rem      <= num_mag >> SAT_SH;
            low_bits <= {num_mag[SAT_SH-1:0], {FRAC_W{1'b0}}};
            quot     <= '0;
            step     <= '0;
          end
        end
        DV_RUN: begin
          rem      <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          quot     <= {quot[SLOPE_W-2:0], fits};
          low_bits <= {low_bits[SLOPE_W-2:0], 1'b0};
          step     <= step + 1'b1;
          if (last_step) begin
            done_q <= 1'b1;
            skip_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.done = done_q;
  assign res.skip = skip_q;
  assign res.quot = quot;

endmodule

// ----- hw/rtl/regression_max_slope_finder.sv -----
// Top level: column accumulators, sequencer and best-slope tracking.
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid / in_stall   | voltage, power, current_delta,
//           |           |                       | column_end, final_item
//   output  | out       | out_valid / out_stall | best_voltage, best_slope, found,
//           |           |                       | overflow
//
// An item that does not close a column uses the shared multiplier, which forms
// x*x and then x*y. An item that closes a column then takes 6 more multiplier
// passes to build the numerator and denominator, then the divider runs a check
// and 31 quotient steps (a skipped or saturated column ends right after the
// check). A final item then loads the result register. Reset is synchronous
// and clears all sums, the best slope and the flags. A stalled result holds its
// register; the block keeps taking items and waits only when a new result is
// ready while the old one is still stalled.
module regression_max_slope_finder import rmsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] voltage,
  input  logic signed [DATA_W-1:0] power,
  input  logic signed [DATA_W-1:0] current_delta,
  input  logic                     column_end,
  input  logic                     final_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] best_voltage,
  output logic [SLOPE_W-1:0]       best_slope,
  output logic                     found,
  output logic                     overflow
);

  top_state_t               state;
  top_state_t               state_next;
  mul_req_t                 mreq;
  mul_res_t                 mres;
  div_res_t                 dres;
  logic                     div_start;

  logic signed [SX_W-1:0]   sum_x;
  logic signed [SX_W-1:0]   sum_y;
  logic signed [SXX_W-1:0]  sum_xx;
  logic signed [SXX_W-1:0]  sum_xy;
  logic [CNT_W-1:0]         pair_count;
  logic signed [ACC_W-1:0]  num_acc;
  logic signed [ACC_W-1:0]  den_acc;
  logic signed [DATA_W-1:0] max_voltage;
  logic [SLOPE_W-1:0]       max_slope;
  logic                     found_flag;
  logic                     overflow_flag;

  logic signed [DATA_W-1:0] volt_q;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] y_q;
  logic                     close_q;
  logic                     fin_q;
  logic                     acc_en;

  logic                     in_acc;
  logic                     room;
  logic                     out_load;
  logic signed [ACC_W-1:0]  prod_acc;
  logic signed [ACC_W-1:0]  prod_hi;
  logic signed [SXX_W-1:0]  prod_sum;

  assign in_acc   = in_valid && !in_stall;
  assign room     = (pair_count < CNT_W'(MAX_SETS));
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);
  assign prod_acc = ACC_W'($signed(mres.prod));
  assign prod_hi  = prod_acc <<< LO_W;
  assign prod_sum = $signed(mres.prod[SXX_W-1:0]);

  rmsf_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .res (mres)
  );

  rmsf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_acc),
    .den   (den_acc),
    .res   (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    div_start  = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.dst   = DST_NONE;
    case (state)
      ST_IDLE: begin
        mreq.a = MUL_W'(power);
        mreq.b = MUL_W'(power);
        if (in_valid) begin
          mreq.dst   = room ? DST_XX : DST_NONE;
          state_next = ST_MXY;
        end
      end
      ST_MXY: begin
        mreq.a     = MUL_W'(x_q);
        mreq.b     = MUL_W'(y_q);
        mreq.dst   = acc_en ? DST_XY : DST_NONE;
        state_next = close_q ? ST_SXSY : ST_IDLE;
      end
      ST_SXSY: begin
        mreq.a     = sum_x;
        mreq.b     = sum_y;
        mreq.dst   = DST_NUM_SUB;
        state_next = ST_SXSX;
      end
      ST_SXSX: begin
        mreq.a     = sum_x;
        mreq.b     = sum_x;
        mreq.dst   = DST_DEN_SUB;
        state_next = ST_NXXL;
      end
      // n times a wide sum is split into a low unsigned and a high signed half.
      ST_NXXL: begin
        mreq.a     = MUL_W'(pair_count);
        mreq.b     = MUL_W'(sum_xx[LO_W-1:0]);
        mreq.dst   = DST_DEN_ADD;
        state_next = ST_NXXH;
      end
      ST_NXXH: begin
        mreq.a     = MUL_W'(pair_count);
        mreq.b     = MUL_W'($signed(sum_xx[SXX_W-1:LO_W]));
        mreq.dst   = DST_DEN_ADD_HI;
        state_next = ST_NXYL;
      end
      ST_NXYL: begin
        mreq.a     = MUL_W'(pair_count);
        mreq.b     = MUL_W'(sum_xy[LO_W-1:0]);
        mreq.dst   = DST_NUM_ADD;
        state_next = ST_NXYH;
      end
      ST_NXYH: begin
        mreq.a     = MUL_W'(pair_count);
        mreq.b     = MUL_W'($signed(sum_xy[SXX_W-1:LO_W]));
        mreq.dst   = DST_NUM_ADD_HI;
        state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (dres.done) begin
          state_next = fin_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_xy        <= '0;
      pair_count    <= '0;
      max_voltage   <= '0;
      max_slope     <= '0;
      found_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_acc) begin
        volt_q  <= voltage;
        x_q     <= power;
        y_q     <= current_delta;
        close_q <= column_end || final_item;
        fin_q   <= final_item;
        acc_en  <= room;
        if (room) begin
          sum_x      <= sum_x + SX_W'(power);
          sum_y      <= sum_y + SX_W'(current_delta);
          pair_count <= pair_count + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end

      case (mres.dst)
        DST_XX:         sum_xx  <= sum_xx + prod_sum;
        DST_XY:         sum_xy  <= sum_xy + prod_sum;
        DST_NUM_SUB:    num_acc <= num_acc - prod_acc;
        DST_NUM_ADD:    num_acc <= num_acc + prod_acc;
        DST_NUM_ADD_HI: num_acc <= num_acc + prod_hi;
        DST_DEN_SUB:    den_acc <= den_acc - prod_acc;
        DST_DEN_ADD:    den_acc <= den_acc + prod_acc;
        DST_DEN_ADD_HI: den_acc <= den_acc + prod_hi;
        default: ;
      endcase

      // The close sequence always follows the x*y state, so start from zero here.
      if (state == ST_MXY) begin
        num_acc <= '0;
        den_acc <= '0;
      end

      if (dres.done) begin
        if (!dres.skip && (dres.quot > max_slope)) begin
          max_slope   <= dres.quot;
          max_voltage <= volt_q;
          found_flag  <= 1'b1;
        end
        sum_x      <= '0;
        sum_y      <= '0;
        sum_xx     <= '0;
        sum_xy     <= '0;
        pair_count <= '0;
      end

      if (out_load) begin
        best_voltage  <= max_voltage;
        best_slope    <= max_slope;
        found         <= found_flag;
        overflow      <= overflow_flag;
        out_valid     <= 1'b1;
        max_voltage   <= '0;
        max_slope     <= '0;
        found_flag    <= 1'b0;
        overflow_flag <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/rmsf_checker.sv -----
// Port-level checks on the regression maximum-slope finder, bound to the top level.
module rmsf_checker import rmsf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [DATA_W-1:0]  voltage,
  input logic [DATA_W-1:0]  power,
  input logic [DATA_W-1:0]  current_delta,
  input logic               column_end,
  input logic               final_item,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DATA_W-1:0]  best_voltage,
  input logic [SLOPE_W-1:0] best_slope,
  input logic               found,
  input logic               overflow
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_voltage) && $stable(best_slope)
      && $stable(found) && $stable(overflow))
    else $error("stalled result changed");

  // Every item keeps the shared multiplier busy, so no item is taken directly behind another.
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // Without a winning column the best voltage and slope stay at zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_slope == '0 && best_voltage == '0)
    else $error("nonzero best values without a found column");

  // A winning column always has a nonzero slope.
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> best_slope != '0)
    else $error("found flag with zero slope");

endmodule

bind regression_max_slope_finder rmsf_checker u_rmsf_checker (.*);
